// File: rtl/core/zapped_audio_delta_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the zapped audio delta decoder
// Clocked assertion helpers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ZAPPED_AUDIO_DELTA_DECODER_ASSERT_SVH
`define ZAPPED_AUDIO_DELTA_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge outside reset
`define ZADD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

// expression must never be true outside reset
`define ZADD_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
    `ZADD_ASSERT(lbl, clk_s, rst_s, !(expr), msg)

`else

`define ZADD_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define ZADD_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)

`endif

`endif

// File: rtl/core/zadd_pkg.sv
// ----------------------------------------------------------------------------
// zadd_pkg
// Types, codes and delta tables shared by the delta decoder modules.
// ----------------------------------------------------------------------------
package zadd_pkg;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // what the next source byte means
    typedef enum logic [1:0] {
        PH_CODE,
        PH_D2,
        PH_D4,
        PH_RAW
    } phase_t;

    // sample job loaded at word accept
    typedef enum logic [2:0] {
        JOB_DELTA5,
        JOB_RUN,
        JOB_D2,
        JOB_D4,
        JOB_RAW
    } job_t;

    // code byte modes (bits 7..6)
    localparam logic [1:0] MODE_D2   = 2'd0;
    localparam logic [1:0] MODE_D4   = 2'd1;
    localparam logic [1:0] MODE_MISC = 2'd2;
    localparam logic [1:0] MODE_RUN  = 2'd3;

    localparam logic [7:0]  PREV_INIT    = 8'h80;
    localparam logic [16:0] CONSUMED_MAX = 17'h1FFFF;

    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic step;     // produce one sample this cycle
    } ctrl_cmd_t;

    typedef struct packed {
        logic go_emit;   // word on the input yields samples
        logic last_step; // current sample is the job's last
        logic out_free;  // output register can take a sample
    } dp_status_t;

    function automatic logic signed [4:0] tab2(input logic [1:0] code);
        logic signed [4:0] d;
        case (code)
            2'd0:    d = -5'sd2;
            2'd1:    d = -5'sd1;
            2'd2:    d = 5'sd0;
            2'd3:    d = 5'sd1;
            default: d = 5'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [4:0] tab4(input logic [3:0] code);
        logic signed [4:0] d;
        case (code)
            4'd0:    d = -5'sd9;
            4'd1:    d = -5'sd8;
            4'd2:    d = -5'sd6;
            4'd3:    d = -5'sd5;
            4'd4:    d = -5'sd4;
            4'd5:    d = -5'sd3;
            4'd6:    d = -5'sd2;
            4'd7:    d = -5'sd1;
            4'd8:    d = 5'sd0;
            4'd9:    d = 5'sd1;
            4'd10:   d = 5'sd2;
            4'd11:   d = 5'sd3;
            4'd12:   d = 5'sd4;
            4'd13:   d = 5'sd5;
            4'd14:   d = 5'sd6;
            4'd15:   d = 5'sd8;
            default: d = 5'sd0;
        endcase
        return d;
    endfunction

    // add with clamp to 0..255
    function automatic logic [7:0] sat_add(input logic [7:0] v, input logic signed [4:0] d);
        logic signed [9:0] s;
        logic [7:0]        r;
        s = $signed({2'b00, v}) + 10'(d);
        if (s < 10'sd0) begin
            r = 8'd0;
        end
        else if (s > 10'sd255) begin
            r = 8'd255;
        end
        else begin
            r = s[7:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/zadd_ctrl.sv
// ----------------------------------------------------------------------------
// zadd_ctrl
// Sequencer: takes one word when idle, then steps out its samples.
// ----------------------------------------------------------------------------
module zadd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  zadd_pkg::dp_status_t   status,
    output zadd_pkg::ctrl_cmd_t    cmd
);

`include "zapped_audio_delta_decoder_assert.svh"

    zadd_pkg::state_t state_reg;
    zadd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zadd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            zadd_pkg::ST_IDLE:
            begin
                if (s_tvalid && status.go_emit)
                begin
                    state_next = zadd_pkg::ST_EMIT;
                end
            end
            zadd_pkg::ST_EMIT:
            begin
                if (status.out_free && status.last_step)
                begin
                    state_next = zadd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zadd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            zadd_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            zadd_pkg::ST_EMIT:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    `ZADD_ASSERT(a_last_step_returns_idle, clk, rst_n, cmd.step && status.last_step |=> state_reg == zadd_pkg::ST_IDLE, "controller did not return to idle after last sample")
    `ZADD_ASSERT(a_no_accept_while_busy, clk, rst_n, cmd.accept && status.go_emit |=> !s_tready, "input taken while samples pending")

endmodule

// File: rtl/core/zadd_datapath.sv
// ----------------------------------------------------------------------------
// zadd_datapath
// Decoder state, code decode, sample arithmetic and output register.
// ----------------------------------------------------------------------------
module zadd_datapath #(
    parameter int BUDGET_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  zadd_pkg::ctrl_cmd_t       cmd,
    output zadd_pkg::dp_status_t      status,
    input  logic [7:0]                in_byte,
    input  logic                      in_frame_start,
    input  logic [BUDGET_WIDTH-1:0]   out_budget,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [7:0]                m_sample,
    output logic                      m_last,
    output logic                      m_done,
    output logic [16:0]               m_consumed
);

`include "zapped_audio_delta_decoder_assert.svh"

    localparam int BW = BUDGET_WIDTH + 2;

    // decoder state
    zadd_pkg::phase_t        phase_reg,    phase_next;
    logic [6:0]              units_reg,    units_next;
    logic [7:0]              prev_reg,     prev_next;
    logic signed [BW-1:0]    budget_reg,   budget_next;
    logic [16:0]             consumed_reg, consumed_next;
    logic                    stopped_reg,  stopped_next;
    logic [5:0]              cnt_reg,      cnt_next;
    logic [1:0]              idx_reg,      idx_next;
    logic                    valid_reg,    valid_next;

    // job and output payload
    zadd_pkg::job_t          job_reg,      job_next;
    logic [7:0]              byte_reg,     byte_next;
    logic                    bound_reg,    bound_next;
    logic [7:0]              smp_reg,      smp_next;
    logic                    last_reg,     last_next;
    logic                    done_reg,     done_next;
    logic [16:0]             cons_reg,     cons_next;

    // accept-side decode
    zadd_pkg::phase_t        phase_eff;
    logic [6:0]              units_eff;
    logic [7:0]              prev_eff;
    logic signed [BW-1:0]    budget_eff;
    logic [16:0]             consumed_eff;
    logic [16:0]             consumed_inc;
    logic                    stopped_eff;
    logic [1:0]              mode;
    logic [5:0]              sub;
    logic [6:0]              units_dec;
    logic                    go_emit;

    // step-side arithmetic
    logic [7:0]              pair_shift;
    logic [3:0]              nib;
    logic [7:0]              smp;
    logic signed [BW-1:0]    budget_dec;
    logic                    spent;
    logic                    last_w;
    logic                    out_free;

    assign out_free = !valid_reg || m_tready;
    assign last_w   = (cnt_reg == '0);

    assign status.go_emit   = go_emit;
    assign status.last_step = last_w;
    assign status.out_free  = out_free;

    assign m_tvalid   = valid_reg;
    assign m_sample   = smp_reg;
    assign m_last     = last_reg;
    assign m_done     = done_reg;
    assign m_consumed = cons_reg;

    // frame start overrides
    always_comb
    begin
        phase_eff    = in_frame_start ? zadd_pkg::PH_CODE : phase_reg;
        units_eff    = in_frame_start ? 7'd0 : units_reg;
        prev_eff     = in_frame_start ? zadd_pkg::PREV_INIT : prev_reg;
        budget_eff   = in_frame_start ? $signed({2'b00, out_budget}) : budget_reg;
        consumed_eff = in_frame_start ? 17'd0 : consumed_reg;
        stopped_eff  = in_frame_start ? (out_budget == '0) : stopped_reg;
        consumed_inc = (consumed_eff == zadd_pkg::CONSUMED_MAX) ?
                       consumed_eff : consumed_eff + 17'd1;
        mode         = in_byte[7:6];
        sub          = in_byte[5:0];
        units_dec    = (units_eff != 7'd0) ? units_eff - 7'd1 : 7'd0;
    end

    // sample for the current step
    always_comb
    begin
        pair_shift = byte_reg >> {idx_reg, 1'b0};
        nib        = idx_reg[0] ? byte_reg[7:4] : byte_reg[3:0];
        case (job_reg)
            zadd_pkg::JOB_DELTA5:
                smp = prev_reg + {{3{byte_reg[4]}}, byte_reg[4:0]};
            zadd_pkg::JOB_RUN:
                smp = prev_reg;
            zadd_pkg::JOB_D2:
                smp = zadd_pkg::sat_add(prev_reg, zadd_pkg::tab2(pair_shift[1:0]));
            zadd_pkg::JOB_D4:
                smp = zadd_pkg::sat_add(prev_reg, zadd_pkg::tab4(nib));
            zadd_pkg::JOB_RAW:
                smp = byte_reg;
            default:
                smp = prev_reg;
        endcase
        budget_dec = budget_reg - BW'(1);
        spent      = budget_dec[BW-1] || (budget_dec == '0);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        units_next    = units_reg;
        prev_next     = prev_reg;
        budget_next   = budget_reg;
        consumed_next = consumed_reg;
        stopped_next  = stopped_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        job_next      = job_reg;
        byte_next     = byte_reg;
        bound_next    = bound_reg;
        smp_next      = smp_reg;
        last_next     = last_reg;
        done_next     = done_reg;
        cons_next     = cons_reg;
        go_emit       = 1'b0;

        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end

        if (cmd.accept)
        begin
            phase_next    = phase_eff;
            units_next    = units_eff;
            prev_next     = prev_eff;
            budget_next   = budget_eff;
            consumed_next = consumed_eff;
            stopped_next  = stopped_eff;
            byte_next     = in_byte;
            idx_next      = 2'd0;
            bound_next    = 1'b1;
            if (!stopped_eff)
            begin
                consumed_next = consumed_inc;
                case (phase_eff)
                    zadd_pkg::PH_CODE:
                    begin
                        case (mode)
                            zadd_pkg::MODE_RUN:
                            begin
                                go_emit  = 1'b1;
                                job_next = zadd_pkg::JOB_RUN;
                                cnt_next = sub;
                            end
                            zadd_pkg::MODE_MISC:
                            begin
                                if (sub[5])
                                begin
                                    go_emit  = 1'b1;
                                    job_next = zadd_pkg::JOB_DELTA5;
                                    cnt_next = 6'd0;
                                end
                                else
                                begin
                                    phase_next = zadd_pkg::PH_RAW;
                                    units_next = {1'b0, sub} + 7'd1;
                                end
                            end
                            zadd_pkg::MODE_D4:
                            begin
                                phase_next = zadd_pkg::PH_D4;
                                units_next = {1'b0, sub} + 7'd1;
                            end
                            zadd_pkg::MODE_D2:
                            begin
                                phase_next = zadd_pkg::PH_D2;
                                units_next = {1'b0, sub} + 7'd1;
                            end
                            default:
                            begin
                                phase_next = zadd_pkg::PH_CODE;
                            end
                        endcase
                    end
                    zadd_pkg::PH_D2, zadd_pkg::PH_D4, zadd_pkg::PH_RAW:
                    begin
                        go_emit    = 1'b1;
                        units_next = units_dec;
                        bound_next = (units_dec == 7'd0);
                        if (units_dec == 7'd0)
                        begin
                            phase_next = zadd_pkg::PH_CODE;
                        end
                        case (phase_eff)
                            zadd_pkg::PH_D2:
                            begin
                                job_next = zadd_pkg::JOB_D2;
                                cnt_next = 6'd3;
                            end
                            zadd_pkg::PH_D4:
                            begin
                                job_next = zadd_pkg::JOB_D4;
                                cnt_next = 6'd1;
                            end
                            default:
                            begin
                                job_next = zadd_pkg::JOB_RAW;
                                cnt_next = 6'd0;
                            end
                        endcase
                    end
                    default:
                    begin
                        phase_next = zadd_pkg::PH_CODE;
                    end
                endcase
            end
        end

        if (cmd.step)
        begin
            prev_next   = smp;
            budget_next = budget_dec;
            cnt_next    = cnt_reg - 6'd1;
            idx_next    = idx_reg + 2'd1;
            valid_next  = 1'b1;
            smp_next    = smp;
            cons_next   = consumed_reg;
            last_next   = last_w;
            done_next   = last_w && bound_reg && spent;
            if (last_w && bound_reg && spent)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= zadd_pkg::PH_CODE;
            units_reg    <= 7'd0;
            prev_reg     <= zadd_pkg::PREV_INIT;
            budget_reg   <= '0;
            consumed_reg <= 17'd0;
            stopped_reg  <= 1'b1;
            cnt_reg      <= 6'd0;
            idx_reg      <= 2'd0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            units_reg    <= units_next;
            prev_reg     <= prev_next;
            budget_reg   <= budget_next;
            consumed_reg <= consumed_next;
            stopped_reg  <= stopped_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        byte_reg  <= byte_next;
        bound_reg <= bound_next;
        smp_reg   <= smp_next;
        last_reg  <= last_next;
        done_reg  <= done_next;
        cons_reg  <= cons_next;
    end

    `ZADD_ASSERT_NEVER(a_done_only_on_last, clk, rst_n, valid_reg && done_reg && !last_reg, "frame_done on a sample that is not the last of its byte")
    `ZADD_ASSERT(a_stop_source, clk, rst_n, $rose(stopped_reg) |-> $past(cmd.accept) || $past(cmd.step && last_w), "decoder stopped outside accept or final step")

endmodule

// File: rtl/core/zapped_audio_delta_decoder.sv
// ----------------------------------------------------------------------------
// zapped_audio_delta_decoder
// Streaming SND1-style ADPCM decoder: compressed bytes in, 8-bit samples out.
// ----------------------------------------------------------------------------
// One byte is taken per word when the decoder is idle; the word is decoded in
// the accept cycle and its samples then leave one per cycle, while the master
// takes them, through a single output register; the next byte is not taken
// until its last sample is in that register. A byte that yields no sample (a
// code that arms a data phase, or any byte while stopped) gives no output. A
// 2-bit delta byte yields 4 samples, a 4-bit delta byte 2, a raw sample or a
// 5-bit delta code 1, and a run code sub + 1 (up to 64). Back pressure on the
// master side stalls the steps. Each frame begins with s_tuser high on its
// first byte, which reloads the budget from the last configuration write,
// presets the previous sample to 128 and clears the byte count. Once the
// budget is spent at a command boundary, the last sample carries tuser high
// and later bytes are swallowed without output until the next frame start.
// A frame start with zero budget is swallowed too. Write cfg_data only while
// the decoder is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module zapped_audio_delta_decoder #(
    parameter int BUDGET_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // compressed byte stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] in_byte
    input  logic                    s_tuser,   // [0] frame_start
    // sample stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // [7:0] sample, [24:8] bytes_consumed
    output logic                    m_tlast,   // last sample from this source byte
    output logic                    m_tuser,   // [0] frame_done
    // budget register write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [BUDGET_WIDTH-1:0] cfg_data
);

    logic [BUDGET_WIDTH-1:0] budget_cfg_reg;
    logic [BUDGET_WIDTH-1:0] budget_cfg_next;

    zadd_pkg::ctrl_cmd_t  cmd;
    zadd_pkg::dp_status_t status;

    logic [7:0]  sample;
    logic [16:0] consumed;

    // budget register, always writable
    assign cfg_ready       = 1'b1;
    assign budget_cfg_next = (cfg_valid && cfg_ready) ? cfg_data : budget_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_cfg_reg <= '0;
        end
        else
        begin
            budget_cfg_reg <= budget_cfg_next;
        end
    end

    // sequencer
    zadd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // decode state, arithmetic and output register
    zadd_datapath #(
        .BUDGET_WIDTH (BUDGET_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_byte        (s_tdata),
        .in_frame_start (s_tuser),
        .out_budget     (budget_cfg_reg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_sample       (sample),
        .m_last         (m_tlast),
        .m_done         (m_tuser),
        .m_consumed     (consumed)
    );

    // pack: sample low, byte count above, zero pad to 32 bits
    assign m_tdata = {7'd0, consumed, sample};

endmodule
